>>> rtl/sfr_pkg.sv
`default_nettype none
package sfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int HOLD_D    = 8;          // held bytes plus the incoming byte
  localparam int HOLD_IW   = $clog2(HOLD_D);
  localparam int CNT_W     = HOLD_IW + 1;
  localparam int WORD_W    = 64;
  localparam int LEN_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int TDATA_W   = 8;

  localparam logic [CNT_W-1:0] MAX_PATTERN     = CNT_W'(8);
  localparam logic [CNT_W-1:0] MAX_REPLACEMENT = CNT_W'(8);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_BYTES = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_REP_BYTES = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_REP_LEN   = CFG_IDX_W'(3);

  typedef struct packed {
    logic load;         // append the accepted byte to the hold buffer
    logic pop;          // emit the front held byte and shift
    logic emit_repl;    // emit replacement byte at the current index
    logic emit_marker;  // emit an empty end marker
    logic out_last;     // tlast for the byte being emitted
    logic clear_cnt;    // drop everything held (after a match)
    logic k_inc;        // advance the replacement index
  } cmd_t;

  typedef struct packed {
    logic match;        // held bytes equal the full pattern
    logic front_ok;     // held bytes are a proper pattern prefix
    logic cnt_one;      // exactly one byte held
    logic repl_zero;    // replacement is empty
    logic k_last;       // replacement index on its final byte
    logic out_free;     // output register can take a byte this cycle
    logic item_last;    // the current transaction closes the stream
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/sfr_datapath.sv
`default_nettype none
module sfr_datapath (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [sfr_pkg::WORD_W-1:0]       cfg_wdata,
  input  wire  [sfr_pkg::BYTE_W-1:0]       in_byte,
  input  wire                              in_last,
  input  wire  sfr_pkg::cmd_t              cmd,
  output sfr_pkg::sts_t                    sts,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [sfr_pkg::BYTE_W-1:0]       out_byte,
  output logic                             out_has,
  output logic                             out_last
);

  logic [sfr_pkg::WORD_W-1:0] pat_r, rep_r;
  logic [sfr_pkg::LEN_W-1:0]  plen_r, rlen_r;

  logic [sfr_pkg::BYTE_W-1:0] hold_r [sfr_pkg::HOLD_D];
  logic [sfr_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [sfr_pkg::CNT_W-1:0]  k_r, k_nxt;
  logic                       last_r;

  logic                       out_valid_r;
  logic [sfr_pkg::BYTE_W-1:0] out_byte_r;
  logic                       out_has_r, out_last_r;

  logic [sfr_pkg::CNT_W-1:0]  eff_pl, eff_rl;
  logic [sfr_pkg::HOLD_D-1:0] eq_vec, in_use;
  logic                       prefix_ok;
  logic                       emit;
  logic [sfr_pkg::BYTE_W-1:0] rep_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      plen_r <= sfr_pkg::LEN_W'(1);
      rep_r  <= '0;
      rlen_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::CFG_PAT_BYTES: pat_r  <= cfg_wdata;
        sfr_pkg::CFG_PAT_LEN:   plen_r <= cfg_wdata[sfr_pkg::LEN_W-1:0];
        sfr_pkg::CFG_REP_BYTES: rep_r  <= cfg_wdata;
        sfr_pkg::CFG_REP_LEN:   rlen_r <= cfg_wdata[sfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range lengths clamp; a zero pattern length acts as one
  always_comb begin
    if (plen_r == '0)
      eff_pl = sfr_pkg::CNT_W'(1);
    else if (sfr_pkg::CNT_W'(plen_r) > sfr_pkg::MAX_PATTERN)
      eff_pl = sfr_pkg::MAX_PATTERN;
    else
      eff_pl = sfr_pkg::CNT_W'(plen_r);
    if (sfr_pkg::CNT_W'(rlen_r) > sfr_pkg::MAX_REPLACEMENT)
      eff_rl = sfr_pkg::MAX_REPLACEMENT;
    else
      eff_rl = sfr_pkg::CNT_W'(rlen_r);
  end

  always_comb begin
    for (int i = 0; i < sfr_pkg::HOLD_D; i++) begin
      eq_vec[i] = (hold_r[i] == pat_r[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]);
      in_use[i] = (sfr_pkg::CNT_W'(i) < cnt_r);
    end
    prefix_ok = &(eq_vec | ~in_use);
  end

  assign rep_byte = rep_r[{k_r[sfr_pkg::HOLD_IW-1:0], 3'b000} +: sfr_pkg::BYTE_W];

  always_comb begin
    sts.match     = (cnt_r == eff_pl) && prefix_ok;
    sts.front_ok  = (cnt_r < eff_pl) && prefix_ok;
    sts.cnt_one   = (cnt_r == sfr_pkg::CNT_W'(1));
    sts.repl_zero = (eff_rl == '0);
    sts.k_last    = (k_r == eff_rl - sfr_pkg::CNT_W'(1));
    sts.out_free  = !out_valid_r || out_ready;
    sts.item_last = last_r;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load)
      cnt_nxt = cnt_r + sfr_pkg::CNT_W'(1);
    else if (cmd.clear_cnt)
      cnt_nxt = '0;
    else if (cmd.pop)
      cnt_nxt = cnt_r - sfr_pkg::CNT_W'(1);
    k_nxt = k_r;
    if (cmd.load)
      k_nxt = '0;
    else if (cmd.k_inc)
      k_nxt = k_r + sfr_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      k_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      k_r   <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hold_r[cnt_r[sfr_pkg::HOLD_IW-1:0]] <= in_byte;
      last_r <= in_last;
    end else if (cmd.pop) begin
      for (int i = 0; i < sfr_pkg::HOLD_D - 1; i++)
        hold_r[i] <= hold_r[i+1];
    end
  end

  assign emit = cmd.pop || cmd.emit_repl || cmd.emit_marker;

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (emit)
      out_valid_r <= 1'b1;
    else if (out_ready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (cmd.pop)
        out_byte_r <= hold_r[0];
      else if (cmd.emit_repl)
        out_byte_r <= rep_byte;
      else
        out_byte_r <= '0;
      out_has_r  <= !cmd.emit_marker;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_has   = out_has_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

>>> rtl/sfr_ctrl.sv
`default_nettype none
module sfr_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire sfr_pkg::sts_t sts,
  output sfr_pkg::cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_REPL = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!sts.match) begin
          state_nxt = ST_SCAN;
        end else if (!sts.repl_zero) begin
          cmd.clear_cnt = 1'b1;
          state_nxt     = ST_REPL;
        end else if (!sts.item_last) begin
          cmd.clear_cnt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (sts.out_free) begin
          // deleted match closes the stream: only an end marker remains
          cmd.clear_cnt   = 1'b1;
          cmd.emit_marker = 1'b1;
          cmd.out_last    = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_REPL: begin
        if (sts.out_free) begin
          cmd.emit_repl = 1'b1;
          cmd.k_inc     = 1'b1;
          cmd.out_last  = sts.item_last && sts.k_last;
          if (sts.k_last)
            state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // release from the front until the rest could still start a match;
        // on the final transaction release everything
        if (!sts.item_last && sts.front_ok) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.pop      = 1'b1;
          cmd.out_last = sts.item_last && sts.cnt_one;
          if (sts.item_last && sts.cnt_one)
            state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= ST_IDLE;
    else
      state_r <= state_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/stream_find_replace_unit.sv
`default_nettype none
// Streaming find-and-replace: each input byte is appended to a small hold
// buffer; a full pattern match emits the replacement (0..8 bytes), otherwise
// bytes are released from the front until the remainder is a proper pattern
// prefix. The transaction with in_tlast flushes everything held and marks the
// final output with out_tlast; if that leaves nothing to send, one empty byte
// with out_tuser low carries the end. One input byte is worked at a time: the
// next is taken only when the controller is back in idle. Released and
// replacement bytes go one per cycle into the single output register while
// that register is free; output stalls hold them. Configuration writes belong
// between streams.
module stream_find_replace_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire  [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [sfr_pkg::WORD_W-1:0]       cfg_wdata,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [sfr_pkg::TDATA_W-1:0]      in_tdata,   // [7:0] in_byte
  input  wire                              in_tlast,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [sfr_pkg::TDATA_W-1:0]      out_tdata,  // [7:0] out_byte
  output logic                             out_tuser,  // [0] has_byte
  output logic                             out_tlast
);

  sfr_pkg::cmd_t cmd;
  sfr_pkg::sts_t sts;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_byte   (in_tdata[sfr_pkg::BYTE_W-1:0]),
    .in_last   (in_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_has   (out_tuser),
    .out_last  (out_tlast)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("new transaction taken while one is in work");

  a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && out_tdata == '0))
    else $error("empty marker not at end of stream");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(cmd.pop || cmd.emit_repl || cmd.emit_marker))
    else $error("output written while idle");

endmodule
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GAP_PCT     = 29;
  localparam int IDLE_WAIT   = 20;    // cycles for a held byte to settle before a write
  localparam int END_WAIT    = 30;
  localparam int STALL_LIMIT = 5000;  // cycles with no transaction on either side
  localparam int HOLD_OFF    = 300;

  // register indexes above the last real one are dropped by the block
  localparam logic [sfr_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = sfr_pkg::CFG_REP_LEN + 1;
  localparam logic [sfr_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       is_last;
  } text_beat_t;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          cfg_we     = 1'b0;
  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [sfr_pkg::WORD_W-1:0]    cfg_wdata  = '0;
  logic                          in_tvalid  = 1'b0;
  logic [sfr_pkg::TDATA_W-1:0]   in_tdata   = '0;
  logic                          in_tlast   = 1'b0;
  logic                          out_tready = 1'b0;
  logic                          in_tready;
  logic                          out_tvalid;
  logic [sfr_pkg::TDATA_W-1:0]   out_tdata;
  logic                          out_tuser;
  logic                          out_tlast;

  // predictor state
  logic [63:0] pat_word  = '0;
  logic [3:0]  pat_len_f = 4'd1;
  logic [63:0] rep_word  = '0;
  logic [3:0]  rep_len_f = '0;
  logic [63:0] held_win  = '0;
  int          held_n    = 0;

  text_beat_t  out_expected[$];
  text_beat_t  head;
  logic [7:0]  alphabet[3];
  int          errors      = 0;
  int          in_gap_pct  = GAP_PCT;
  int          out_gap_pct = GAP_PCT;
  int          hold_left   = 0;
  int          stall_cycles = 0;

  stream_find_replace_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] in_byte
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] out_byte
    .out_tuser  (out_tuser),  // [0] has_byte
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pat_eff_len();
    int l;
    l = pat_len_f;
    if (l < 1) l = 1;
    if (l > int'(sfr_pkg::MAX_PATTERN)) l = int'(sfr_pkg::MAX_PATTERN);
    if (l > 8) l = 8;
    return l;
  endfunction

  function automatic int rep_eff_len();
    int l;
    l = rep_len_f;
    if (l > int'(sfr_pkg::MAX_REPLACEMENT)) l = int'(sfr_pkg::MAX_REPLACEMENT);
    if (l > 8) l = 8;
    return l;
  endfunction

  function automatic logic pat_prefix_ok(input logic [63:0] win, input int first, input int n);
    logic [63:0] mask;
    mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
    return ((((win >> (8 * first)) ^ pat_word) & mask) == 64'd0);
  endfunction

  // appends the byte to the held window and queues the bytes it releases
  function automatic void predict_replace(input logic [7:0] b, input logic last);
    text_beat_t  beats[8];
    logic [63:0] win;
    int          n, plen, rlen, first, cnt, k;
    win = held_win;
    n = held_n;
    win[8*n +: 8] = b;
    n++;
    plen = pat_eff_len();
    rlen = rep_eff_len();
    first = 0;
    cnt = 0;
    if (n == plen && pat_prefix_ok(win, 0, n)) begin
      for (k = 0; k < rlen; k++) begin
        beats[cnt] = {rep_word[8*k +: 8], 2'b10};
        cnt++;
      end
      first = n;
    end else begin
      // release from the front until the rest is a proper pattern prefix
      while (first < n && !((n - first) < plen && pat_prefix_ok(win, first, n - first))) begin
        beats[cnt] = {win[8*first +: 8], 2'b10};
        cnt++;
        first++;
      end
    end
    if (last) begin
      while (first < n) begin
        beats[cnt] = {win[8*first +: 8], 2'b10};
        cnt++;
        first++;
      end
      if (cnt == 0) begin
        beats[0] = '0;
        cnt = 1;
      end
      beats[cnt-1].is_last = 1'b1;
    end
    for (k = 0; k < cnt; k++) out_expected.push_back(beats[k]);
    held_n = n - first;
    held_win = win >> (8 * first);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_replace(b, last);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      sfr_pkg::CFG_PAT_BYTES: pat_word  = val;
      sfr_pkg::CFG_PAT_LEN:   pat_len_f = val[3:0];
      sfr_pkg::CFG_REP_BYTES: rep_word  = val;
      sfr_pkg::CFG_REP_LEN:   rep_len_f = val[3:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_config(input logic [63:0] pat, input logic [3:0] plen,
                            input logic [63:0] rep, input logic [3:0] rlen,
                            input bit spare);
    write_reg(sfr_pkg::CFG_PAT_BYTES, pat);
    write_reg(sfr_pkg::CFG_PAT_LEN, 64'(plen));
    write_reg(sfr_pkg::CFG_REP_BYTES, rep);
    write_reg(sfr_pkg::CFG_REP_LEN, 64'(rlen));
    if (spare)
      write_reg(sfr_pkg::CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                {$urandom, $urandom});
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending, collect every pending result, let a held byte settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (out_expected.size() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  // reset pattern is a single zero byte with an empty replacement
  task automatic test_reset_state();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);   // match on the last byte, nothing left: end marker
    drain();
  endtask

  task automatic test_length_limits();
    int k;
    // length fields above 8 act as 8; a spare index write must change nothing
    set_config('1, 4'd15, 64'h4847_4645_4443_4241, 4'd15, 1'b1);
    for (k = 0; k < 8; k++) send_byte(8'hFF, k == 7);
    drain();
    // pattern length 0 acts as 1
    set_config(64'h61, 4'd0, 64'h7A79, 4'd2, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h61, 1'b1);
    drain();
  endtask

  // a failed partial match must restart one byte later
  task automatic test_partial_restart();
    set_config(64'h62_6161, 4'd3, 64'h5A, 4'd1, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);
    drain();
  endtask

  // shorter pattern while more bytes are held than the new pattern length
  task automatic test_mid_stream_change();
    int k;
    set_config(64'h6665_6463_6261, 4'd6, 64'h2A2A, 4'd2, 1'b0);
    for (k = 0; k < 5; k++) send_byte(8'h61 + k, 1'b0);
    drain();
    set_config(64'h6564, 4'd2, 64'h2A2A, 4'd2, 1'b0);
    send_byte(8'h78, 1'b1);
    drain();
  endtask

  // each 0x70 byte expands to eight bytes while the receiver holds off
  task automatic test_backpressure();
    int k;
    set_config(64'h70, 4'd1, {$urandom, $urandom}, 4'd8, 1'b0);
    in_gap_pct = 0;
    out_gap_pct = 0;
    @(posedge clk);
    hold_left = HOLD_OFF;
    @(negedge clk);
    for (k = 0; k < 30; k++)
      send_byte(($urandom_range(3) != 0) ? 8'h70 : 8'h71, k == 29);
    drain();
    in_gap_pct = GAP_PCT;
    out_gap_pct = GAP_PCT;
  endtask

  task automatic random_streams(input int n_items, input bit cut_last);
    logic [7:0] txt[$];
    int         sent, len, r, take, k;
    bit         closing;
    sent = 0;
    while (sent < n_items) begin
      txt.delete();
      len = $urandom_range(1, 16);
      while (txt.size() < len) begin
        r = $urandom_range(99);
        if (r < 35) begin
          take = $urandom_range(1) ? pat_eff_len() : $urandom_range(1, pat_eff_len());
          for (k = 0; k < take; k++) txt.push_back(pat_word[8*k +: 8]);
        end else if (r < 85) begin
          txt.push_back(alphabet[$urandom_range(2)]);
        end else begin
          txt.push_back(8'($urandom_range(255)));
        end
      end
      closing = (sent + txt.size() >= n_items);
      for (k = 0; k < txt.size(); k++) begin
        send_byte(txt[k], (k == txt.size() - 1) && !(cut_last && closing));
        sent++;
      end
    end
    drain();   // a cut stream keeps its held bytes into the next setting
  endtask

  task automatic test_random_text();
    logic [63:0] pat;
    logic [3:0]  plen, rlen;
    int          phase, k, r;
    for (phase = 0; phase < 9; phase++) begin
      for (k = 0; k < 3; k++) alphabet[k] = 8'($urandom_range(255));
      if (phase == 0) begin
        alphabet[0] = 8'h00;
        alphabet[1] = 8'hFF;
      end
      for (k = 0; k < 8; k++) pat[8*k +: 8] = alphabet[$urandom_range(2)];
      r = $urandom_range(9);
      plen = (r == 0) ? 4'd0 : (r == 9) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 8));
      rlen = ($urandom_range(9) == 9) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      set_config(pat, plen, {$urandom, $urandom}, rlen, $urandom_range(3) == 0);
      in_gap_pct  = (phase == 4) ? 0 : GAP_PCT;
      out_gap_pct = (phase == 4) ? 0 : GAP_PCT;
      random_streams(50, $urandom_range(3) == 0);
    end
    in_gap_pct = GAP_PCT;
    out_gap_pct = GAP_PCT;
  endtask

  // receiver
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= out_gap_pct);
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (out_expected.size() == 0) begin
        $error("unexpected result: out_byte %02h has_byte %0b out_last %0b",
               out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        head = out_expected.pop_front();
        if (out_tdata !== head.data) begin
          $error("out_byte: expected %02h, got %02h", head.data, out_tdata);
          errors++;
        end
        if (out_tuser !== head.has_byte) begin
          $error("has_byte: expected %0b, got %0b", head.has_byte, out_tuser);
          errors++;
        end
        if (out_tlast !== head.is_last) begin
          $error("out_last: expected %0b, got %0b", head.is_last, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_state();
    test_length_limits();
    test_partial_restart();
    test_mid_stream_change();
    test_backpressure();
    test_random_text();
    repeat (END_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
